@@ hdl/arc_point_sampler_defines.svh @@
// ----------------------------------------------------------------------------
// arc_point_sampler_defines
// Assertion macros shared by the arc point sampler modules.
// ----------------------------------------------------------------------------
`ifndef ARC_POINT_SAMPLER_DEFINES_SVH
`define ARC_POINT_SAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define APS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define APS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define APS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define APS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/aps_pkg.sv @@
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants of the arc point sampler.
// ----------------------------------------------------------------------------
package aps_pkg;
    localparam int COORD_BITS = 24;
    localparam int ANGLE_BITS = 24;
    localparam int ITERS = 16;
    localparam int ITER_BITS = 4;
    localparam int STEP_BITS = 6;
    localparam int MAX_STEPS = 63;
    localparam int CW = 48;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = 24'h800000;
    localparam logic signed [CW-1:0] GAIN_Q30 = 48'sd652032875;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_DIV, ST_VEC, ST_ROT, ST_MUL, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic vec_step;
        logic rot_start;
        logic rot_step;
        logic mul;
        logic out_load;
        logic advance;
        logic [ITER_BITS-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic last_point;
    } sts_t;

    function automatic logic [ANGLE_BITS-1:0] atan_entry(input logic [ITER_BITS-1:0] i);
        case (i)
            4'd0: atan_entry = 24'd2097152;
            4'd1: atan_entry = 24'd1238021;
            4'd2: atan_entry = 24'd654136;
            4'd3: atan_entry = 24'd332050;
            4'd4: atan_entry = 24'd166669;
            4'd5: atan_entry = 24'd83416;
            4'd6: atan_entry = 24'd41718;
            4'd7: atan_entry = 24'd20860;
            4'd8: atan_entry = 24'd10430;
            4'd9: atan_entry = 24'd5215;
            4'd10: atan_entry = 24'd2608;
            4'd11: atan_entry = 24'd1304;
            4'd12: atan_entry = 24'd652;
            4'd13: atan_entry = 24'd326;
            4'd14: atan_entry = 24'd163;
            4'd15: atan_entry = 24'd81;
            default: atan_entry = 24'd0;
        endcase
    endfunction
endpackage

@@ hdl/arc_point_sampler.sv @@
// ----------------------------------------------------------------------------
// arc_point_sampler
// Samples max(arc_steps,1)+1 points of a circular arc from centre, start,
// radius and sweep.
// ----------------------------------------------------------------------------
// An arc takes a load, the bit-serial sweep divider (24 steps and a completion
// state) and 16 vectoring iterations for the start angle, then per point a
// rotation setup, 16 iterations of the one shared rotator, a multiply and an
// output, plus any output stall. One arc at a time.
module arc_point_sampler
    import aps_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [STEP_BITS-1:0]         cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-2:0]        radius,
    input  logic signed [15:0]           sweep,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         last
);
    logic [STEP_BITS-1:0] steps_reg;
    cmd_t cmd;
    sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= STEP_BITS'(16);
        end
        else if (cfg_we)
        begin
            steps_reg <= cfg_wdata;
        end
    end

    aps_control u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
    );

    aps_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .arc_steps(steps_reg),
        .center_x(center_x), .center_y(center_y), .start_x(start_x),
        .start_y(start_y), .radius(radius), .sweep(sweep),
        .point_x(point_x), .point_y(point_y), .last(last)
    );
endmodule

@@ hdl/aps_datapath.sv @@
// ----------------------------------------------------------------------------
// aps_datapath
// Divider, shared rotator, multiply and saturate stages of the sampler.
// ----------------------------------------------------------------------------
`include "arc_point_sampler_defines.svh"
module aps_datapath
    import aps_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output sts_t                         sts,
    input  logic [STEP_BITS-1:0]         arc_steps,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic signed [COORD_BITS-1:0] start_x,
    input  logic signed [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-2:0]        radius,
    input  logic signed [15:0]           sweep,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         last
);
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [COORD_BITS-2:0] r_reg;
    logic [STEP_BITS-1:0] steps_reg, idx_reg;
    logic [ANGLE_BITS-1:0] ang_reg, inc_reg, z_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic zs_reg, neg_reg;
    logic signed [ANGLE_BITS-1:0] zr_reg;
    logic [23:0] quo_reg, rem_reg, num_reg;
    logic div_neg_reg;
    logic [4:0] dcnt_reg;
    logic signed [55:0] px_reg, py_reg;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg;
    logic olast_reg;

    logic signed [COORD_BITS:0] dx, dy;
    logic signed [CW-1:0] xs, ys;
    logic [24:0] rtrial;
    logic signed [ANGLE_BITS-1:0] zf;
    logic signed [COORD_BITS+1:0] sumx, sumy;
    logic signed [55:0] rx, ry;
    logic signed [31:0] tx, ty;
    logic [STEP_BITS-1:0] eff_steps;

    assign eff_steps = (arc_steps == '0) ? STEP_BITS'(1) : arc_steps;
    assign dx = $signed({start_x[COORD_BITS-1], start_x}) - $signed({center_x[COORD_BITS-1], center_x});
    assign dy = $signed({start_y[COORD_BITS-1], start_y}) - $signed({center_y[COORD_BITS-1], center_y});
    assign xs = x_reg >>> cmd.iter;
    assign ys = y_reg >>> cmd.iter;
    assign rtrial = {rem_reg, num_reg[23]} - {19'd0, steps_reg};
    assign zf = $signed(ang_reg);
    // rotator output is within +/-2^31 in Q30
    assign tx = neg_reg ? 32'(-x_reg) : 32'(x_reg);
    assign ty = neg_reg ? 32'(-y_reg) : 32'(y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.load)
        begin
            idx_reg <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg + STEP_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg <= center_x;
            cy_reg <= center_y;
            r_reg <= radius;
            steps_reg <= eff_steps;
            div_neg_reg <= sweep[15];
            num_reg <= sweep[15] ? 24'(-{{8{sweep[15]}}, sweep, 8'd0} >>> 0) :
                       {sweep, 8'd0} & 24'hFFFFFF;
            rem_reg <= '0;
            quo_reg <= '0;
            dcnt_reg <= '0;
            if (dx < 0)
            begin
                x_reg <= -($signed({{(CW-COORD_BITS-1){dx[COORD_BITS]}}, dx}) <<< 20);
                y_reg <= -($signed({{(CW-COORD_BITS-1){dy[COORD_BITS]}}, dy}) <<< 20);
                z_reg <= HALF_TURN;
            end
            else
            begin
                x_reg <= $signed({{(CW-COORD_BITS-1){dx[COORD_BITS]}}, dx}) <<< 20;
                y_reg <= $signed({{(CW-COORD_BITS-1){dy[COORD_BITS]}}, dy}) <<< 20;
                z_reg <= '0;
            end
            zs_reg <= (dx == 0) && (dy == 0);
        end
        if (cmd.div_step)
        begin
            if (!rtrial[24])
            begin
                rem_reg <= rtrial[23:0];
                quo_reg <= {quo_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[22:0], num_reg[23]};
                quo_reg <= {quo_reg[22:0], 1'b0};
            end
            num_reg <= {num_reg[22:0], 1'b0};
            dcnt_reg <= dcnt_reg + 5'd1;
        end
        if (cmd.vec_step)
        begin
            if (y_reg < 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_entry(cmd.iter);
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_entry(cmd.iter);
            end
            if (cmd.iter == ITER_BITS'(ITERS - 1))
            begin
                ang_reg <= zs_reg ? '0 : ((y_reg < 0) ? z_reg - atan_entry(cmd.iter)
                                                       : z_reg + atan_entry(cmd.iter));
                inc_reg <= div_neg_reg ? -quo_reg : quo_reg;
            end
        end
        if (cmd.rot_start)
        begin
            x_reg <= GAIN_Q30;
            y_reg <= '0;
            if (zf > $signed(24'h400000))
            begin
                zr_reg <= zf - $signed(HALF_TURN);
                neg_reg <= 1'b1;
            end
            else if (zf < -$signed(24'h400000))
            begin
                zr_reg <= zf + $signed(HALF_TURN);
                neg_reg <= 1'b1;
            end
            else
            begin
                zr_reg <= zf;
                neg_reg <= 1'b0;
            end
        end
        if (cmd.rot_step)
        begin
            if (zr_reg >= 0)
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                zr_reg <= zr_reg - $signed(atan_entry(cmd.iter));
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                zr_reg <= zr_reg + $signed(atan_entry(cmd.iter));
            end
        end
        if (cmd.mul)
        begin
            px_reg <= $signed({1'b0, r_reg}) * tx;
            py_reg <= $signed({1'b0, r_reg}) * ty;
        end
        if (cmd.out_load)
        begin
            ox_reg <= sumx > $signed(26'sh7FFFFF) ? 24'sh7FFFFF :
                      sumx < -$signed(26'sh800000) ? -24'sh800000 : sumx[COORD_BITS-1:0];
            oy_reg <= sumy > $signed(26'sh7FFFFF) ? 24'sh7FFFFF :
                      sumy < -$signed(26'sh800000) ? -24'sh800000 : sumy[COORD_BITS-1:0];
            olast_reg <= idx_reg == steps_reg;
        end
        if (cmd.advance)
        begin
            ang_reg <= ang_reg + inc_reg;
        end
    end

    assign rx = (px_reg + 56'sd536870912) >>> 30;
    assign ry = (py_reg + 56'sd536870912) >>> 30;
    assign sumx = $signed({{2{cx_reg[COORD_BITS-1]}}, cx_reg}) + $signed(rx[COORD_BITS+1:0]);
    assign sumy = $signed({{2{cy_reg[COORD_BITS-1]}}, cy_reg}) + $signed(ry[COORD_BITS+1:0]);

    assign sts.div_done = dcnt_reg == 5'd24;
    assign sts.last_point = idx_reg == steps_reg;
    assign point_x = ox_reg;
    assign point_y = oy_reg;
    assign last = olast_reg;

    `APS_ASSERT_IMP(a_idx_range, clk, rst_n, cmd.advance, idx_reg < steps_reg)
    `APS_ASSERT_IMP(a_one_op, clk, rst_n, cmd.vec_step, !cmd.rot_step && !cmd.div_step)
    `APS_ASSERT_NEXT(a_load_idx, clk, rst_n, cmd.load, idx_reg == '0)
endmodule

@@ hdl/aps_control.sv @@
// ----------------------------------------------------------------------------
// aps_control
// Sequencer: division, vectoring, then one rotation per point.
// ----------------------------------------------------------------------------
`include "arc_point_sampler_defines.svh"
module aps_control
    import aps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd
);
    state_t state_reg, state_next;
    logic [ITER_BITS-1:0] it_reg, it_next;
    logic ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            it_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            it_reg <= it_next;
            ov_reg <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        it_next = it_reg;
        ov_next = ov_reg && out_stall;
        cmd = '0;
        cmd.iter = it_reg;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    it_next = '0;
                    state_next = ST_VEC;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_VEC:
            begin
                cmd.vec_step = 1'b1;
                it_next = it_reg + ITER_BITS'(1);
                if (it_reg == ITER_BITS'(ITERS - 1))
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.rot_start = 1'b1;
                it_next = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cmd.rot_step = 1'b1;
                it_next = it_reg + ITER_BITS'(1);
                if (it_reg == ITER_BITS'(ITERS - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    if (sts.last_point)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next = ST_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = ov_reg;

    `APS_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall)
    `APS_ASSERT_NEXT(a_out_after, clk, rst_n, cmd.out_load, ov_reg)
    `APS_ASSERT_IMP(a_no_overrun, clk, rst_n, cmd.out_load, !ov_reg || !out_stall)
endmodule
